// ----- hdl/psa_pkg.sv -----
package psa_pkg;

    // number of fractions in one run
    localparam int FRACTION_COUNT = 64;

    localparam int FRAC_W  = 56;
    localparam int PART_W  = 62;
    localparam int COUNT_W = $clog2(FRACTION_COUNT + 1);
    localparam int IDX_W   = $clog2(FRACTION_COUNT);
    localparam int BIT_W   = $clog2(PART_W);
    // divider working width: twice the remainder plus one fraction
    localparam int T_W     = PART_W + 2;

    typedef logic [FRAC_W-1:0]  frac_t;
    typedef logic [PART_W-1:0]  part_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [IDX_W-1:0]   idx_t;

    // how the shares of a run are formed
    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_COPY,
        MODE_DIV
    } mode_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_DECIDE,
        ST_DIV_RD,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT_RD,
        ST_EMIT_LATCH,
        ST_EMIT_HOLD
    } state_t;

    // request to the divider
    typedef struct packed {
        logic  start;
        frac_t frac;
    } div_req_t;

endpackage

// ----- hdl/proportional_split_with_adjust_top.sv -----
// Proportional split with round-robin adjustment.
// Input channel (in_valid/in_stall): one request per fraction, 64 per run,
// taken one per cycle while loading; part_value of the last request is used.
// Output channel (out_valid/out_stall): 64 shares in index order, last_of_run
// high on the final one.
// After the last fraction the divider works each share in turn, one bit of
// part_value per cycle (skipped when part is zero or above the total).
// Emission then reads both memories and presents each share through the
// read, latch and hold states, so a new share is not started until the
// previous one is taken; the round-robin deficit is added during emission.
// in_stall is high from the last fraction until the last share is taken.
// A stalled share is held in the output register until taken.
// Reset clears the control state and running total; memory contents are
// left as they are and always written before being read.
module proportional_split_with_adjust_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  psa_pkg::frac_t  fraction,
    input  psa_pkg::part_t  part_value,
    output logic            out_valid,
    input  logic            out_stall,
    output psa_pkg::frac_t  part_fraction,
    output logic            last_of_run
);
    import psa_pkg::*;

    state_t state_reg, state_next;
    mode_t  mode_reg;
    count_t load_count_reg;
    idx_t   idx_reg;
    part_t  total_reg;
    part_t  part_reg;
    part_t  sum_reg;
    count_t deficit_reg;
    logic   out_valid_reg;
    frac_t  part_fraction_reg;
    logic   last_reg;

    logic     in_accept;
    logic     div_done;
    frac_t    div_q;
    div_req_t div_req;
    frac_t    frac_rd;
    frac_t    share_rd;
    part_t    sum_next;
    logic     idx_last;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_LOAD);
    assign idx_last  = (idx_reg == idx_t'(FRACTION_COUNT - 1));
    assign sum_next  = sum_reg + {{(PART_W-FRAC_W){1'b0}}, div_q};

    // source fractions
    psa_ram #(.WIDTH(FRAC_W), .DEPTH(FRACTION_COUNT)) u_frac_ram (
        .clk   (clk),
        .we    (in_accept),
        .waddr (load_count_reg[IDX_W-1:0]),
        .wdata (fraction),
        .raddr (idx_reg),
        .rdata (frac_rd)
    );

    // truncated shares
    psa_ram #(.WIDTH(FRAC_W), .DEPTH(FRACTION_COUNT)) u_share_ram (
        .clk   (clk),
        .we    (state_reg == ST_DIV_WAIT && div_done),
        .waddr (idx_reg),
        .wdata (div_q),
        .raddr (idx_reg),
        .rdata (share_rd)
    );

    assign div_req.start = (state_reg == ST_DIV_START);
    assign div_req.frac  = frac_rd;

    psa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .part     (part_reg),
        .total    (total_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_accept && load_count_reg == count_t'(FRACTION_COUNT - 1))
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (part_reg != '0 && part_reg <= total_reg)
                begin
                    state_next = ST_DIV_RD;
                end
                else
                begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_DIV_RD:     state_next = ST_DIV_START;
            ST_DIV_START:  state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = idx_last ? ST_EMIT_RD : ST_DIV_RD;
                end
            end
            ST_EMIT_RD:    state_next = ST_EMIT_LATCH;
            ST_EMIT_LATCH: state_next = ST_EMIT_HOLD;
            ST_EMIT_HOLD:
            begin
                if (!out_stall)
                begin
                    state_next = idx_last ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default:       state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // run control and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg <= '0;
            total_reg      <= '0;
            part_reg       <= '0;
            idx_reg        <= '0;
            mode_reg       <= MODE_ZERO;
            sum_reg        <= '0;
            deficit_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_LOAD:
                begin
                    if (in_accept)
                    begin
                        load_count_reg <= load_count_reg + count_t'(1);
                        total_reg      <= total_reg + {{(PART_W-FRAC_W){1'b0}}, fraction};
                        part_reg       <= part_value;
                    end
                end
                ST_DECIDE:
                begin
                    idx_reg     <= '0;
                    sum_reg     <= '0;
                    deficit_reg <= '0;
                    if (part_reg == '0)
                    begin
                        mode_reg <= MODE_ZERO;
                    end
                    else if (part_reg > total_reg)
                    begin
                        mode_reg <= MODE_COPY;
                    end
                    else
                    begin
                        mode_reg <= MODE_DIV;
                    end
                end
                ST_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        sum_reg <= sum_next;
                        if (idx_last)
                        begin
                            idx_reg     <= '0;
                            deficit_reg <= count_t'(part_reg - sum_next);
                        end
                        else
                        begin
                            idx_reg <= idx_reg + idx_t'(1);
                        end
                    end
                end
                ST_EMIT_LATCH:
                begin
                    out_valid_reg <= 1'b1;
                    if (mode_reg == MODE_DIV && deficit_reg != '0 && share_rd < frac_rd)
                    begin
                        deficit_reg <= deficit_reg - count_t'(1);
                    end
                end
                ST_EMIT_HOLD:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        if (idx_last)
                        begin
                            idx_reg        <= '0;
                            load_count_reg <= '0;
                            total_reg      <= '0;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + idx_t'(1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // output payload, with the round-robin unit added in index order
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT_LATCH)
        begin
            last_reg <= idx_last;
            case (mode_reg)
                MODE_ZERO: part_fraction_reg <= '0;
                MODE_COPY: part_fraction_reg <= frac_rd;
                MODE_DIV:
                begin
                    if (deficit_reg != '0 && share_rd < frac_rd)
                    begin
                        part_fraction_reg <= share_rd + FRAC_W'(1);
                    end
                    else
                    begin
                        part_fraction_reg <= share_rd;
                    end
                end
                default:   part_fraction_reg <= share_rd;
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign part_fraction = part_fraction_reg;
    assign last_of_run   = last_reg;

endmodule

// ----- hdl/psa_ram.sv -----
module psa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/psa_div.sv -----
module psa_div (
    input  logic             clk,
    input  logic             rst_n,
    input  psa_pkg::div_req_t req,
    input  psa_pkg::part_t   part,
    input  psa_pkg::part_t   total,
    output logic             done,
    output psa_pkg::frac_t   quotient
);
    import psa_pkg::*;

    logic             running_reg;
    logic             done_reg;
    logic [BIT_W-1:0] bit_reg;
    frac_t            f_reg;
    part_t            r_reg;
    frac_t            q_reg;

    logic [T_W-1:0] t;
    logic [T_W-1:0] tot1;
    logic [T_W-1:0] tot2;
    logic [T_W-1:0] d1;
    logic [T_W-1:0] d2;
    part_t          r_next;
    frac_t          q_next;

    // one bit of part per cycle: f*p = q*total + r, r below total
    always_comb
    begin
        t    = ({2'b00, r_reg} << 1)
             + (part[bit_reg] ? {{(T_W-FRAC_W){1'b0}}, f_reg} : '0);
        tot1 = {2'b00, total};
        tot2 = tot1 << 1;
        d1   = t - tot1;
        d2   = t - tot2;
        if (t >= tot2)
        begin
            r_next = d2[PART_W-1:0];
            q_next = (q_reg << 1) + FRAC_W'(2);
        end
        else if (t >= tot1)
        begin
            r_next = d1[PART_W-1:0];
            q_next = (q_reg << 1) + FRAC_W'(1);
        end
        else
        begin
            r_next = t[PART_W-1:0];
            q_next = q_reg << 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                running_reg <= 1'b1;
            end
            else if (running_reg && bit_reg == '0)
            begin
                running_reg <= 1'b0;
                done_reg    <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            f_reg   <= req.frac;
            r_reg   <= '0;
            q_reg   <= '0;
            bit_reg <= BIT_W'(PART_W - 1);
        end
        else if (running_reg)
        begin
            r_reg <= r_next;
            q_reg <= q_next;
            if (bit_reg != '0)
            begin
                bit_reg <= bit_reg - BIT_W'(1);
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
